[sv/brm_pkg.sv]
`timescale 1ns / 1ps

package brm_pkg;

	// Default sizes, handed down through the top-level parameters
	localparam int PROG_DEPTH_DEF = 64;
	localparam int NUM_REGS_DEF   = 6;

	// Field widths
	localparam int DATA_W = 32;
	localparam int OPR_W  = 24;
	localparam int RIDX_W = 3;
	localparam int ADDR_W = 6;
	localparam int BOUND_W = 3;
	localparam int LEN_W  = 7;
	localparam int CFG_W  = 7;

	// Stream widths, padded to whole bytes
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		OPC_ADDR = 4'd0,
		OPC_ADDI = 4'd1,
		OPC_MULR = 4'd2,
		OPC_MULI = 4'd3,
		OPC_BANR = 4'd4,
		OPC_BANI = 4'd5,
		OPC_BORR = 4'd6,
		OPC_BORI = 4'd7,
		OPC_SETR = 4'd8,
		OPC_SETI = 4'd9,
		OPC_GTIR = 4'd10,
		OPC_GTRI = 4'd11,
		OPC_GTRR = 4'd12,
		OPC_EQIR = 4'd13,
		OPC_EQRI = 4'd14,
		OPC_EQRR = 4'd15
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_HALT    = 2'd1,
		ST_BAD_REG = 2'd2
	} status_t;

	// One program word as held in the program store
	typedef struct packed {
		logic [RIDX_W-1:0] c;
		logic [OPR_W-1:0]  b;
		logic [OPR_W-1:0]  a;
		opcode_t           opcode;
	} prog_word_t;

	// Input item, last declared field (op) in the lowest bits
	typedef struct packed {
		logic [DATA_W-1:0] write_value;
		logic [RIDX_W-1:0] reg_index;
		logic [RIDX_W-1:0] operand_c;
		logic [OPR_W-1:0]  operand_b;
		logic [OPR_W-1:0]  operand_a;
		opcode_t           opcode;
		logic [ADDR_W-1:0] address;
		op_t               op;
	} item_t;

	// Result item, last declared field (status) in the lowest bits
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] next_ip;
		status_t           status;
	} result_t;

	// Operand a is a register index for this opcode
	function automatic logic uses_reg_a(opcode_t opc);
		logic r;
		unique case (opc)
			OPC_SETI, OPC_GTIR, OPC_EQIR: r = 1'b0;
			default:                      r = 1'b1;
		endcase
		return r;
	endfunction

	// Operand b is a register index for this opcode
	function automatic logic uses_reg_b(opcode_t opc);
		logic r;
		unique case (opc)
			OPC_ADDR, OPC_MULR, OPC_BANR, OPC_BORR,
			OPC_GTIR, OPC_GTRR, OPC_EQIR, OPC_EQRR: r = 1'b1;
			default:                                r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[sv/brm_ram.sv]
`timescale 1ns / 1ps

module brm_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port (old data on a collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/brm_alu.sv]
`timescale 1ns / 1ps

module brm_alu
	import brm_pkg::*;
(
	input  opcode_t           opcode,
	input  logic [DATA_W-1:0] va,
	input  logic [DATA_W-1:0] vb,
	output logic [DATA_W-1:0] res
);

	logic [DATA_W-1:0] sum;
	logic [DATA_W-1:0] prod;
	logic              gt;
	logic              eq;

	assign sum  = va + vb;
	assign prod = va * vb;  // low 32 bits only
	assign gt   = $signed(va) > $signed(vb);
	assign eq   = va == vb;

	// Register and immediate forms share one operation
	always_comb begin
		unique case (opcode)
			OPC_ADDR, OPC_ADDI:           res = sum;
			OPC_MULR, OPC_MULI:           res = prod;
			OPC_BANR, OPC_BANI:           res = va & vb;
			OPC_BORR, OPC_BORI:           res = va | vb;
			OPC_SETR, OPC_SETI:           res = va;
			OPC_GTIR, OPC_GTRI, OPC_GTRR: res = DATA_W'(gt);
			OPC_EQIR, OPC_EQRI, OPC_EQRR: res = DATA_W'(eq);
		endcase
	end

endmodule

[sv/brm_core.sv]
`timescale 1ns / 1ps

module brm_core
	import brm_pkg::*;
#(
	parameter int NUM_REGS   = NUM_REGS_DEF,
	parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,        // item in the input register is retired
	input  item_t              item,
	input  logic [BOUND_W-1:0] bound_reg,
	input  logic [LEN_W-1:0]   prog_len,
	input  prog_word_t         word,       // program word at the current pointer
	output result_t            result,
	output logic [DATA_W-1:0]  ip_next     // pointer after this cycle, for the fetch
);

	localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [OPR_W-1:0] NREG = OPR_W'(NUM_REGS);

	logic [DATA_W-1:0] reg_q [NUM_REGS];
	logic [DATA_W-1:0] ip_q;

	logic [DATA_W-1:0] eff_len;
	logic [DATA_W-1:0] len_x;
	logic              in_prog;

	logic [OPR_W-1:0]  bound_x;
	logic [OPR_W-1:0]  c_x;
	logic [OPR_W-1:0]  ri_x;
	logic [RW-1:0]     b_sel;
	logic [RW-1:0]     a_idx;
	logic [RW-1:0]     bi_idx;
	logic [RW-1:0]     c_idx;
	logic [RW-1:0]     ri_idx;
	logic              ua;
	logic              ub;
	logic              bound_ok;
	logic              opnd_ok;
	logic              ri_ok;
	logic [DATA_W-1:0] va;
	logic [DATA_W-1:0] vb;
	logic [DATA_W-1:0] alu_res;
	logic [DATA_W-1:0] ip_step;

	logic              mirror_en;
	logic              wr_en;
	logic [RW-1:0]     wr_idx;
	logic [DATA_W-1:0] wr_val;
	logic [DATA_W-1:0] ip_d;

	// Effective program length: min(program_length, PROG_DEPTH)
	assign len_x   = DATA_W'(prog_len);
	assign eff_len = (len_x < DATA_W'(PROG_DEPTH)) ? len_x : DATA_W'(PROG_DEPTH);
	assign in_prog = ip_q < eff_len;

	// Index range checks
	assign bound_x  = OPR_W'(bound_reg);
	assign c_x      = OPR_W'(word.c);
	assign ri_x     = OPR_W'(item.reg_index);
	assign b_sel    = bound_x[RW-1:0];
	assign a_idx    = word.a[RW-1:0];
	assign bi_idx   = word.b[RW-1:0];
	assign c_idx    = c_x[RW-1:0];
	assign ri_idx   = ri_x[RW-1:0];
	assign ua       = uses_reg_a(word.opcode);
	assign ub       = uses_reg_b(word.opcode);
	assign bound_ok = bound_x < NREG;
	assign ri_ok    = ri_x < NREG;
	assign opnd_ok  = (c_x < NREG) && (!ua || (word.a < NREG)) && (!ub || (word.b < NREG));

	// Operands see the pointer already mirrored into the bound register
	assign va = ua ? ((a_idx == b_sel) ? ip_q : reg_q[a_idx]) : DATA_W'(word.a);
	assign vb = ub ? ((bi_idx == b_sel) ? ip_q : reg_q[bi_idx]) : DATA_W'(word.b);

	brm_alu u_alu (
		.opcode (word.opcode),
		.va     (va),
		.vb     (vb),
		.res    (alu_res)
	);

	// New pointer is reloaded from the bound register, then incremented
	assign ip_step = ((c_idx == b_sel) ? alu_res : ip_q) + DATA_W'(1);

	// Item decode
	always_comb begin
		result.status = ST_OK;
		result.value  = '0;
		mirror_en     = 1'b0;
		wr_en         = 1'b0;
		wr_idx        = ri_idx;
		wr_val        = item.write_value;
		ip_d          = ip_q;
		unique case (item.op)
			OP_LOAD: begin
			end
			OP_READ: begin
				if (ri_ok) begin
					result.value = reg_q[ri_idx];
				end else begin
					result.status = ST_BAD_REG;
				end
			end
			OP_WRITE: begin
				if (ri_ok) begin
					wr_en        = 1'b1;
					result.value = item.write_value;
				end else begin
					result.status = ST_BAD_REG;
				end
			end
			OP_STEP: begin
				priority if (!in_prog) begin
					result.status = ST_HALT;
				end else if (!bound_ok || !opnd_ok) begin
					result.status = ST_BAD_REG;
				end else begin
					mirror_en     = 1'b1;
					wr_en         = 1'b1;
					wr_idx        = c_idx;
					wr_val        = alu_res;
					ip_d          = ip_step;
					result.value  = alu_res;
					result.status = (ip_step < eff_len) ? ST_OK : ST_HALT;
				end
			end
		endcase
		result.next_ip = ip_d;
	end

	assign ip_next = adv ? ip_d : ip_q;

	// Register file and pointer; the destination write wins over the mirror
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				reg_q[i] <= '0;
			end
			ip_q <= '0;
		end else if (adv) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (mirror_en && (b_sel == RW'(i))) begin
					reg_q[i] <= ip_q;
				end
				if (wr_en && (wr_idx == RW'(i))) begin
					reg_q[i] <= wr_val;
				end
			end
			ip_q <= ip_d;
		end
	end

endmodule

[sv/bound_ip_register_machine.sv]
`timescale 1ns / 1ps

// Six-register machine with a bound instruction pointer. Each input transfer
// loads a program word, reads or writes a register, or executes one step; each
// produces exactly one result transfer. An item passes through an input
// register and a result register, and one item is taken every cycle when the
// output is not stalled. The program store is a single-write, registered-read
// RAM; the word at the next pointer is fetched ahead of its step, with a bypass
// for a load that hits that slot, so back-to-back steps run at one per cycle
// when the output is not stalled. Configuration writes take effect at once and
// are meant only while the block is idle. Executing a program slot that was
// never loaded returns undefined fields.
module bound_ip_register_machine
	import brm_pkg::*;
#(
	parameter int PROG_DEPTH = PROG_DEPTH_DEF,
	parameter int NUM_REGS   = NUM_REGS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// op, address, opcode, operand_a, operand_b, operand_c, reg_index, write_value
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// status, next_ip, value
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int AW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
	localparam int XW = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(result_t);

	localparam logic CFG_BOUND = 1'b0;
	localparam logic CFG_LEN   = 1'b1;

	logic [BOUND_W-1:0] bound_q;
	logic [LEN_W-1:0]   len_q;

	logic               v_s1;
	item_t              item_s1;
	logic               m_valid_q;
	result_t            res_q;
	logic               adv;

	result_t            result;
	logic [DATA_W-1:0]  ip_next;

	logic [XW-1:0]      addr_x;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	prog_word_t         ram_wdata;
	logic [$bits(prog_word_t)-1:0] ram_rdata;
	logic               byp_q;
	prog_word_t         byp_word_q;
	prog_word_t         word;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
			len_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOUND: bound_q <= cfg_data[BOUND_W-1:0];
				CFG_LEN:   len_q   <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// Handshake: retire the input register whenever the result register frees up
	assign adv      = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, res_q};

	// Program store: loads beyond the store are dropped
	assign addr_x    = XW'(item_s1.address);
	assign ram_we    = adv && (item_s1.op == OP_LOAD) && (addr_x < XW'(PROG_DEPTH));
	assign ram_waddr = addr_x[AW-1:0];
	assign ram_wdata = '{c: item_s1.operand_c, b: item_s1.operand_b,
	                     a: item_s1.operand_a, opcode: item_s1.opcode};
	assign ram_raddr = ip_next[AW-1:0];

	brm_ram #(
		.WIDTH  ($bits(prog_word_t)),
		.DEPTH  (PROG_DEPTH),
		.ADDR_W (AW)
	) u_prog_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Bypass a load that lands on the slot being fetched in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_word_q <= ram_wdata;
	end

	assign word = byp_q ? byp_word_q : prog_word_t'(ram_rdata);

	brm_core #(
		.NUM_REGS   (NUM_REGS),
		.PROG_DEPTH (PROG_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (item_s1),
		.bound_reg (bound_q),
		.prog_len  (len_q),
		.word      (word),
		.result    (result),
		.ip_next   (ip_next)
	);

endmodule

[bench/brm_tb_pkg.sv]
`timescale 1ns / 1ps

package brm_tb_pkg;

	// Register indexes on the configuration write port
	localparam logic CFG_BOUND  = 1'b0;
	localparam logic CFG_LENGTH = 1'b1;

endpackage

[bench/brm_checker.sv]
`timescale 1ns / 1ps

// Watches both streams and the config port, keeps its own copy of the machine
// and checks every result transfer against the oldest predicted result.
module brm_checker
	import brm_pkg::*;
	import brm_tb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// op, address, opcode, operand_a, operand_b, operand_c, reg_index, write_value
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// status, next_ip, value
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     pending,
	output int                     errors,
	output int                     checked,
	output int                     halts,
	output int                     bad_refs
);

	localparam int NREG  = NUM_REGS_DEF;
	localparam int DEPTH = PROG_DEPTH_DEF;

	// Machine state as the predictor sees it
	logic [DATA_W-1:0]  regs [NREG];
	logic [DATA_W-1:0]  ip;
	prog_word_t         prog [DEPTH];
	logic [BOUND_W-1:0] mirror_idx;
	logic [LEN_W-1:0]   prog_len;

	result_t expected_results [$];
	int fail_count = 0;
	int check_count = 0;
	int halt_count = 0;
	int bad_count = 0;

	assign errors   = fail_count;
	assign checked  = check_count;
	assign halts    = halt_count;
	assign bad_refs = bad_count;

	// bit 0: operand a names a register, bit 1: operand b names a register
	function automatic logic [1:0] reg_operands(opcode_t opc);
		logic [1:0] r;
		case (opc)
			OPC_ADDR, OPC_MULR, OPC_BANR, OPC_BORR, OPC_GTRR, OPC_EQRR: r = 2'b11;
			OPC_SETI:                                                    r = 2'b00;
			OPC_GTIR, OPC_EQIR:                                          r = 2'b10;
			default:                                                     r = 2'b01;
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] alu_result(opcode_t opc, logic [DATA_W-1:0] va,
			logic [DATA_W-1:0] vb);
		logic [DATA_W-1:0] r;
		case (opc)
			OPC_ADDR, OPC_ADDI:           r = va + vb;
			OPC_MULR, OPC_MULI:           r = va * vb;
			OPC_BANR, OPC_BANI:           r = va & vb;
			OPC_BORR, OPC_BORI:           r = va | vb;
			OPC_SETR, OPC_SETI:           r = va;
			OPC_GTIR, OPC_GTRI, OPC_GTRR: r = ($signed(va) > $signed(vb)) ? 32'd1 : 32'd0;
			default:                      r = (va == vb) ? 32'd1 : 32'd0;
		endcase
		return r;
	endfunction

	// Applies one input item to the state and returns the result it produces
	function automatic result_t execute_item(item_t it);
		result_t r;
		prog_word_t w;
		logic [1:0] uses;
		logic [DATA_W-1:0] va, vb, eff;
		r.status = ST_OK;
		r.value = '0;
		eff = (prog_len < DEPTH) ? DATA_W'(prog_len) : DATA_W'(DEPTH);
		case (it.op)
			OP_LOAD: begin
				prog[it.address].opcode = it.opcode;
				prog[it.address].a = it.operand_a;
				prog[it.address].b = it.operand_b;
				prog[it.address].c = it.operand_c;
			end
			OP_READ: begin
				if (it.reg_index < NREG) r.value = regs[it.reg_index];
				else r.status = ST_BAD_REG;
			end
			OP_WRITE: begin
				if (it.reg_index < NREG) begin
					regs[it.reg_index] = it.write_value;
					r.value = it.write_value;
				end else begin
					r.status = ST_BAD_REG;
				end
			end
			default: begin
				if (ip >= eff) begin
					r.status = ST_HALT;
				end else if (mirror_idx >= NREG) begin
					r.status = ST_BAD_REG;
				end else begin
					w = prog[ip[ADDR_W-1:0]];
					uses = reg_operands(w.opcode);
					if (w.c >= NREG || (uses[0] && w.a >= NREG) || (uses[1] && w.b >= NREG)) begin
						r.status = ST_BAD_REG;
					end else begin
						// mirror the pointer, execute, then reload the pointer from the mirror
						regs[mirror_idx] = ip;
						va = uses[0] ? regs[w.a] : DATA_W'(w.a);
						vb = uses[1] ? regs[w.b] : DATA_W'(w.b);
						r.value = alu_result(w.opcode, va, vb);
						regs[w.c] = r.value;
						ip = regs[mirror_idx] + 32'd1;
						r.status = (ip < eff) ? ST_OK : ST_HALT;
					end
				end
			end
		endcase
		r.next_ip = ip;
		return r;
	endfunction

	task automatic note_failure(result_t want, result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: status exp %0d got %0d, next_ip exp %h got %h, value exp %h got %h",
				want.status, got.status, want.next_ip, got.next_ip, want.value, got.value);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) regs[i] = '0;
			ip = '0;
			mirror_idx = '0;
			prog_len = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			// result side first: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result transfer: %h", m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_count++;
					if (got.status !== want.status || got.next_ip !== want.next_ip ||
							got.value !== want.value)
						note_failure(want, got);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_BOUND) mirror_idx = cfg_data[BOUND_W-1:0];
				else prog_len = cfg_data[LEN_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				want = execute_item(s_tdata[$bits(item_t)-1:0]);
				if (want.status == ST_HALT) halt_count++;
				if (want.status == ST_BAD_REG) bad_count++;
				expected_results.insert(expected_results.size(), want);
			end
			pending <= expected_results.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
	import brm_pkg::*;
	import brm_tb_pkg::*;

	localparam int NREG        = NUM_REGS_DEF;
	localparam int DEPTH       = PROG_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MIXED_OPS   = 290;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [CFG_W-1:0]       cfg_data = '0;

	int pending, errors, checked, halts, bad_refs;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	// stimulus-side view of the configuration, used to shape programs
	logic [BOUND_W-1:0] mirror_reg = '0;
	int prog_len = 0;

	bound_ip_register_machine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	brm_checker result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pending  (pending),
		.errors   (errors),
		.checked  (checked),
		.halts    (halts),
		.bad_refs (bad_refs)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("status: fail");
			$finish;
		end
	end

	function automatic item_t random_item();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic item_t step_item();
		item_t it;
		it = random_item();
		it.op = OP_STEP;
		return it;
	endfunction

	function automatic item_t reg_item(op_t op, int idx, logic [DATA_W-1:0] val);
		item_t it;
		it = random_item();
		it.op = op;
		it.reg_index = RIDX_W'(idx);
		it.write_value = val;
		return it;
	endfunction

	function automatic item_t load_item(int slot, prog_word_t w);
		item_t it;
		it = random_item();
		it.op = OP_LOAD;
		it.address = ADDR_W'(slot);
		it.opcode = w.opcode;
		it.operand_a = w.a;
		it.operand_b = w.b;
		it.operand_c = w.c;
		return it;
	endfunction

	function automatic prog_word_t word(opcode_t o, logic [OPR_W-1:0] a, logic [OPR_W-1:0] b,
			logic [RIDX_W-1:0] c);
		prog_word_t w;
		w.opcode = o;
		w.a = a;
		w.b = b;
		w.c = c;
		return w;
	endfunction

	function automatic logic [OPR_W-1:0] pick_operand(logic is_reg);
		if (is_reg) return OPR_W'($urandom_range(NREG - 1));
		case ($urandom_range(3))
			0:       return OPR_W'($urandom_range(15));
			1:       return '1;
			default: return OPR_W'($urandom);
		endcase
	endfunction

	// ordinary instruction that never writes the mirror register
	function automatic prog_word_t plain_word();
		prog_word_t w;
		w.opcode = opcode_t'($urandom_range(15));
		w.a = pick_operand(uses_reg_a(w.opcode));
		w.b = pick_operand(uses_reg_b(w.opcode));
		w.c = RIDX_W'($urandom_range(NREG - 2));
		if (w.c >= mirror_reg) w.c++;
		return w;
	endfunction

	// jump that lands inside the program
	function automatic prog_word_t jump_word();
		return word(OPC_SETI, OPR_W'($urandom_range(prog_len - 2)), OPR_W'($urandom), mirror_reg);
	endfunction

	// writes the mirror with a value that keeps the pointer inside the program
	function automatic prog_word_t branch_word();
		opcode_t cmp_ops [6] = '{OPC_GTIR, OPC_GTRI, OPC_GTRR, OPC_EQIR, OPC_EQRI, OPC_EQRR};
		prog_word_t w;
		case ($urandom_range(2))
			0: w = jump_word();
			1: w = word(OPC_BANI, OPR_W'(mirror_reg), OPR_W'($urandom), mirror_reg);
			default: begin
				w.opcode = cmp_ops[$urandom_range(5)];
				w.a = pick_operand(uses_reg_a(w.opcode));
				w.b = pick_operand(uses_reg_b(w.opcode));
				w.c = mirror_reg;
			end
		endcase
		return w;
	endfunction

	// last slot always loops back, so the program keeps running
	function automatic prog_word_t program_word(int slot);
		if (slot == prog_len - 1) return jump_word();
		if ($urandom_range(99) < 10) return branch_word();
		return plain_word();
	endfunction

	// instruction with an out-of-range register index
	function automatic prog_word_t broken_word();
		prog_word_t w;
		w = plain_word();
		if (uses_reg_a(w.opcode) && $urandom_range(2) == 0)
			w.a = OPR_W'($urandom_range(24'hFFFFFF, NREG));
		else if (uses_reg_b(w.opcode) && $urandom_range(1) == 0)
			w.b = OPR_W'($urandom_range(24'hFFFFFF, NREG));
		else
			w.c = RIDX_W'(NREG + $urandom_range(1));
		return w;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(5))
			0:       return '0;
			1:       return 32'h7FFFFFFF;
			2:       return 32'h80000000;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_reg();
		if ($urandom_range(9) == 0) return NREG + $urandom_range(1);
		return $urandom_range(NREG - 1);
	endfunction

	// holds tvalid high until the item is taken
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, it};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every outstanding result drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [BOUND_W-1:0] b, input logic [CFG_W-1:0] len);
		wait_idle();
		write_cfg(CFG_BOUND, CFG_W'(b));
		write_cfg(CFG_LENGTH, len);
		mirror_reg = b;
		prog_len = (len < DEPTH) ? len : DEPTH;
	endtask

	// extremes, every op and the halt and bad-index corners
	task automatic directed_checks();
		set_config(3'd0, 7'd0);
		send_item(step_item());
		send_item(reg_item(OP_WRITE, 0, 32'h7FFFFFFF));
		send_item(reg_item(OP_WRITE, 1, 32'h80000000));
		send_item(reg_item(OP_WRITE, 7, 32'hFFFFFFFF));
		send_item(reg_item(OP_READ, 6, '0));
		send_item(reg_item(OP_READ, 1, '0));
		send_item(load_item(0, word(OPC_GTRR, 24'd0, 24'd1, 3'd3)));
		send_item(load_item(1, word(OPC_MULI, 24'd0, 24'hFFFFFF, 3'd2)));
		send_item(load_item(2, word(OPC_EQRR, 24'd6, 24'd0, 3'd2)));
		send_item(load_item(3, word(OPC_GTIR, 24'hFFFFFF, 24'd1, 3'd1)));
		send_item(load_item(63, word(OPC_EQRR, 24'hFFFFFF, 24'hFFFFFF, 3'd7)));
		// mirror index out of range
		set_config(3'd6, 7'd4);
		send_item(step_item());
		set_config(3'd7, 7'd4);
		send_item(step_item());
		set_config(3'd5, 7'd4);
		send_item(step_item());
		send_item(step_item());
		// bad operand stalls the pointer until the slot is reloaded
		send_item(step_item());
		send_item(load_item(2, word(OPC_SETI, 24'hFFFFFF, 24'd0, 3'd4)));
		send_item(step_item());
		// last slot steps out of the program, then stays out
		send_item(step_item());
		send_item(step_item());
		send_item(reg_item(OP_READ, 5, '0));
		send_item(reg_item(OP_READ, 2, '0));
	endtask

	task automatic random_op();
		int pick, slot;
		pick = $urandom_range(99);
		if (pick < 68) begin
			send_item(step_item());
		end else if (pick < 78) begin
			send_item(reg_item(OP_WRITE, pick_reg(), pick_value()));
		end else if (pick < 86) begin
			send_item(reg_item(OP_READ, pick_reg(), pick_value()));
		end else if (pick < 97) begin
			slot = $urandom_range(DEPTH - 1);
			send_item(load_item(slot, program_word(slot)));
		end else begin
			// corrupt a live slot for a few steps, then repair it
			slot = $urandom_range(prog_len - 1);
			send_item(load_item(slot, broken_word()));
			repeat (3) send_item(step_item());
			send_item(load_item(slot, program_word(slot)));
		end
	endtask

	// lengths never shrink between phases, so the pointer stays reachable
	task automatic run_phase(input logic [BOUND_W-1:0] b, input logic [CFG_W-1:0] len,
			input int idle, input int stall, input bit leave);
		set_config(b, len);
		idle_pct = idle;
		stall_pct = stall;
		for (int s = 0; s < DEPTH; s++) send_item(load_item(s, program_word(s)));
		repeat (MIXED_OPS) random_op();
		if (leave) begin
			// straight-line program walks the pointer off the end
			for (int s = 0; s < prog_len; s++) send_item(load_item(s, plain_word()));
			repeat (prog_len + 2) send_item(step_item());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		run_phase(3'd0, 7'd9, 0, 0, 1'b1);
		run_phase(3'd5, 7'd20, 48, 0, 1'b1);
		run_phase(3'd3, 7'd64, 0, 48, 1'b0);
		run_phase(3'd2, 7'd127, 20, 20, 1'b1);
		wait_idle();
		$display("summary: %0d results checked (%0d halted, %0d bad index) over four traffic phases",
			checked, halts, bad_refs);
		$display("summary: mirror register 0 to 7, program length 0 to 127, all sixteen opcodes");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
